FILE: src/fbpa_pkg.sv
// shared types, codes and constants for the fixed block pool allocator
package fbpa_pkg;

  // fixed field widths
  localparam int AddrBits  = 32;
  localparam int SizeBits  = 17;
  localparam int CountBits = 9;
  localparam int ShiftBits = 5;
  localparam int LastBits  = 34;
  localparam int MinShift  = 2;

  // queue sizing between the parts
  localparam int CmdqDepth  = 4;
  localparam int ResqDepth  = 4;
  localparam int QCountBits = $clog2(ResqDepth + 1);

  // configuration register indexes
  localparam logic [1:0] CfgBase     = 2'd0;
  localparam logic [1:0] CfgSize     = 2'd1;
  localparam logic [1:0] CfgMaxCount = 2'd2;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_REBUILD = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_FOREIGN   = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } stat_e;

  // what the back part does with a command
  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef struct packed {
    stat_e                 status;
    logic [CountBits-1:0]  in_use;
  } meta_t;

  typedef struct packed {
    stat_e                 status;
    logic [AddrBits-1:0]   granted;
    logic [CountBits-1:0]  in_use;
  } res_t;

  // log2 of the block size, rounded up to a power of two, at least four bytes
  function automatic logic [ShiftBits-1:0] block_shift(input logic [SizeBits-1:0] req);
    logic [ShiftBits-1:0] sh;
    sh = ShiftBits'(MinShift);
    for (int i = MinShift; i < SizeBits; i++) begin
      if ({1'b0, req} > ((SizeBits + 1)'(1) << i)) begin
        sh = ShiftBits'(i + 1);
      end
    end
    return sh;
  endfunction

endpackage

FILE: src/fbpa_ram.sv
// generic single write port ram with registered read
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/fbpa_fifo.sv
// small register fifo used for the command and result queues
module fbpa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [WIDTH-1:0]                 data_i,
  input  logic                             pop_i,
  output logic [WIDTH-1:0]                 data_o,
  output logic                             empty_o,
  output logic                             full_o,
  output logic [$clog2(DEPTH + 1)-1:0]     count_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign count_o = count_q;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // no word is pushed into a full queue by its producer
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("fifo push while full");

endmodule

FILE: src/fbpa_front.sv
// front part: config registers, pool bookkeeping and command classification
module fbpa_front #(
  parameter int MAX_BLOCKS = 256,
  parameter int IDX_W      = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [fbpa_pkg::AddrBits-1:0]   cfg_data_i,
  // accepted word
  input  logic                            accept_i,
  input  logic [1:0]                      mode_i,
  input  logic [fbpa_pkg::AddrBits-1:0]   address_i,
  // command to the back part
  output fbpa_pkg::op_e                   cmd_op_o,
  output logic [IDX_W-1:0]                cmd_idx_o,
  output logic [ADDR_WIDTH-1:0]           cmd_data_o,
  output fbpa_pkg::meta_t                 cmd_meta_o
);

  localparam int CntW       = fbpa_pkg::CountBits;
  localparam int LastW      = fbpa_pkg::LastBits;
  localparam int ResetCount = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam int ResetTail  = ResetCount % MAX_BLOCKS;
  localparam int ResetLast  = (ResetCount - 1) * 4;

  // config registers
  logic [fbpa_pkg::AddrBits-1:0]  base_cfg_q;
  logic [fbpa_pkg::ShiftBits-1:0] shift_cfg_q;
  logic [CntW-1:0]                max_cfg_q;

  // pool latched at rebuild
  logic [fbpa_pkg::AddrBits-1:0]  pool_base_q, pool_base_d;
  logic [fbpa_pkg::ShiftBits-1:0] pool_shift_q, pool_shift_d;
  logic [CntW-1:0]                pool_count_q, pool_count_d;
  logic [LastW-1:0]               pool_last_q, pool_last_d;

  // queue bookkeeping; pops_q counts pops since rebuild, saturating at the pool
  // size, so early pops take freshly generated addresses instead of memory
  logic [IDX_W-1:0]               head_q, head_d;
  logic [IDX_W-1:0]               tail_q, tail_d;
  logic [CntW-1:0]                count_q, count_d;
  logic [CntW-1:0]                pops_q, pops_d;

  logic                           gen_avail;
  logic                           in_pool;
  logic [LastW-1:0]               gen_sum;
  logic [63:0]                    gen_wide;
  logic [63:0]                    addr_wide;
  logic [CntW-1:0]                new_count;
  logic [LastW-1:0]               new_last;
  fbpa_pkg::stat_e                status;

  assign gen_avail = (pops_q < pool_count_q);
  assign gen_sum   = LastW'(pool_base_q) + (LastW'(pops_q) << pool_shift_q);
  assign gen_wide  = 64'(gen_sum);
  assign addr_wide = 64'(address_i);
  assign in_pool   = (pool_count_q != '0) && (LastW'(address_i) >= LastW'(pool_base_q))
                     && (LastW'(address_i) <= pool_last_q);

  // pool size for a rebuild, saturated to the storage depth
  assign new_count = (int'(max_cfg_q) > MAX_BLOCKS) ? CntW'(MAX_BLOCKS) : max_cfg_q;
  assign new_last  = (new_count == '0) ? '0
                   : LastW'(base_cfg_q) + (LastW'(new_count - 1'b1) << shift_cfg_q);

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_cfg_q  <= '0;
      shift_cfg_q <= fbpa_pkg::ShiftBits'(fbpa_pkg::MinShift);
      max_cfg_q   <= CntW'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fbpa_pkg::CfgBase:     base_cfg_q  <= cfg_data_i;
        fbpa_pkg::CfgSize:
          shift_cfg_q <= fbpa_pkg::block_shift(cfg_data_i[fbpa_pkg::SizeBits-1:0]);
        fbpa_pkg::CfgMaxCount: max_cfg_q   <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // classify the word and update the pool state
  always_comb begin
    pool_base_d  = pool_base_q;
    pool_shift_d = pool_shift_q;
    pool_count_d = pool_count_q;
    pool_last_d  = pool_last_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    pops_d       = pops_q;
    status       = fbpa_pkg::STAT_OK;
    cmd_op_o     = fbpa_pkg::OP_PASS;
    cmd_idx_o    = head_q;
    cmd_data_o   = '0;
    case (fbpa_pkg::mode_e'(mode_i))
      fbpa_pkg::MODE_ALLOC: begin
        if (count_q >= pool_count_q) begin
          status = fbpa_pkg::STAT_EXHAUSTED;
        end else begin
          if (gen_avail) begin
            cmd_data_o = gen_wide[ADDR_WIDTH-1:0];
            pops_d     = pops_q + 1'b1;
          end else begin
            cmd_op_o = fbpa_pkg::OP_READ;
          end
          head_d  = (head_q == IDX_W'(MAX_BLOCKS - 1)) ? '0 : head_q + 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      fbpa_pkg::MODE_FREE: begin
        if (!in_pool) begin
          status = fbpa_pkg::STAT_FOREIGN;
        end else if (count_q == '0) begin
          status = fbpa_pkg::STAT_OVERFLOW;
        end else begin
          cmd_op_o   = fbpa_pkg::OP_WRITE;
          cmd_idx_o  = tail_q;
          cmd_data_o = addr_wide[ADDR_WIDTH-1:0];
          tail_d     = (tail_q == IDX_W'(MAX_BLOCKS - 1)) ? '0 : tail_q + 1'b1;
          count_d    = count_q - 1'b1;
        end
      end
      fbpa_pkg::MODE_REBUILD: begin
        pool_base_d  = base_cfg_q;
        pool_shift_d = shift_cfg_q;
        pool_count_d = new_count;
        pool_last_d  = new_last;
        head_d       = '0;
        tail_d       = (int'(new_count) >= MAX_BLOCKS) ? '0 : IDX_W'(new_count);
        count_d      = '0;
        pops_d       = '0;
      end
      default: ;
    endcase
    cmd_meta_o.status = status;
    cmd_meta_o.in_use = count_d;
  end

  // pool state registers, reset as a rebuild from the reset config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_shift_q <= fbpa_pkg::ShiftBits'(fbpa_pkg::MinShift);
      pool_count_q <= CntW'(ResetCount);
      pool_last_q  <= LastW'(ResetLast);
      head_q       <= '0;
      tail_q       <= IDX_W'(ResetTail);
      count_q      <= '0;
      pops_q       <= '0;
    end else if (accept_i) begin
      pool_base_q  <= pool_base_d;
      pool_shift_q <= pool_shift_d;
      pool_count_q <= pool_count_d;
      pool_last_q  <= pool_last_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      pops_q       <= pops_d;
    end
  end

  // in-use count stays within the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= pool_count_q)
    else $error("in-use count above pool size");

  // generated addresses never run past the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni) pops_q <= pool_count_q)
    else $error("generated pop count above pool size");

  // a generated address is only handed out while head still tracks the pop count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (mode_i == fbpa_pkg::MODE_ALLOC) && (count_q < pool_count_q) && gen_avail)
      |-> (int'(head_q) == int'(pops_q)))
    else $error("head out of step with generated pops");

endmodule

FILE: src/fbpa_back.sv
// back part: free list memory access and result assembly
module fbpa_back #(
  parameter int MAX_BLOCKS = 256,
  parameter int IDX_W      = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command queue side
  input  logic                                cmd_valid_i,
  input  fbpa_pkg::op_e                       cmd_op_i,
  input  logic [IDX_W-1:0]                    cmd_idx_i,
  input  logic [ADDR_WIDTH-1:0]               cmd_data_i,
  input  fbpa_pkg::meta_t                     cmd_meta_i,
  output logic                                cmd_take_o,
  // result queue side
  input  logic [fbpa_pkg::QCountBits-1:0]     res_count_i,
  output logic                                res_push_o,
  output fbpa_pkg::res_t                      res_o
);

  localparam int LvlW = fbpa_pkg::QCountBits + 1;

  logic                  s1_valid_q;
  fbpa_pkg::op_e         s1_op_q;
  logic [ADDR_WIDTH-1:0] s1_data_q;
  fbpa_pkg::meta_t       s1_meta_q;
  logic [ADDR_WIDTH-1:0] ram_rdata;
  logic [63:0]           rd_wide;
  logic [63:0]           pass_wide;
  logic                  do_write;
  logic                  do_read;

  // take a word only if the result queue has room for it and the one in flight
  assign cmd_take_o = cmd_valid_i
                      && ((LvlW'(res_count_i) + LvlW'(s1_valid_q)) < LvlW'(fbpa_pkg::ResqDepth));
  assign do_write   = cmd_take_o && (cmd_op_i == fbpa_pkg::OP_WRITE);
  assign do_read    = cmd_take_o && (cmd_op_i == fbpa_pkg::OP_READ);

  fbpa_ram #(
    .WIDTH (ADDR_WIDTH),
    .DEPTH (MAX_BLOCKS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (cmd_idx_i),
    .wdata_i (cmd_data_i),
    .re_i    (do_read),
    .raddr_i (cmd_idx_i),
    .rdata_o (ram_rdata)
  );

  // stage that waits for the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_take_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      s1_op_q   <= cmd_op_i;
      s1_data_q <= cmd_data_i;
      s1_meta_q <= cmd_meta_i;
    end
  end

  // result assembly
  assign rd_wide   = 64'(ram_rdata);
  assign pass_wide = 64'(s1_data_q);

  always_comb begin
    res_o.status = s1_meta_q.status;
    res_o.in_use = s1_meta_q.in_use;
    case (s1_op_q)
      fbpa_pkg::OP_READ:  res_o.granted = rd_wide[fbpa_pkg::AddrBits-1:0];
      fbpa_pkg::OP_PASS:  res_o.granted = pass_wide[fbpa_pkg::AddrBits-1:0];
      default:            res_o.granted = '0;
    endcase
  end

  assign res_push_o = s1_valid_q;

  // the result stage never finds the result queue full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (LvlW'(res_count_i) < LvlW'(fbpa_pkg::ResqDepth)))
    else $error("result pushed into full queue");

endmodule

FILE: src/fixed_block_pool_allocator.sv
// fixed block pool allocator top level: front, command queue, back, result queue
// path: an accepted word passes the command queue, the back stage register and the result queue
// throughput: one word per cycle for allocate, free, rebuild alike while the command queue
//   is not full; a rebuild needs no memory pass, as early pops generate base plus index times size
// reset: pool rebuilt from the reset config (base 0, size 4, 256 blocks) at once,
//   queues empty, no memory clearing pass
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [fbpa_pkg::AddrBits-1:0]     cfg_data_i,
  // input queue side
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        mode_i,
  input  logic [fbpa_pkg::AddrBits-1:0]     address_i,
  // result queue side
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        status_o,
  output logic [fbpa_pkg::AddrBits-1:0]     granted_address_o,
  output logic [fbpa_pkg::CountBits-1:0]    in_use_o
);

  localparam int IdxW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int MetaW = $bits(fbpa_pkg::meta_t);
  localparam int CmdW  = 2 + IdxW + ADDR_WIDTH + MetaW;
  localparam int ResW  = $bits(fbpa_pkg::res_t);

  logic                  accept;
  logic                  cfg_we;
  fbpa_pkg::op_e         f_op;
  logic [IdxW-1:0]       f_idx;
  logic [ADDR_WIDTH-1:0] f_data;
  fbpa_pkg::meta_t       f_meta;
  logic [CmdW-1:0]       cmdq_in, cmdq_out;
  logic                  cmdq_empty;
  logic [fbpa_pkg::QCountBits-1:0] cmdq_count;
  logic                  cmd_take;
  logic                  res_push;
  fbpa_pkg::res_t        res_in, res_out;
  logic [fbpa_pkg::QCountBits-1:0] resq_count;
  logic                  resq_full;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = push && !full;

  fbpa_front #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDX_W      (IdxW),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .address_i   (address_i),
    .cmd_op_o    (f_op),
    .cmd_idx_o   (f_idx),
    .cmd_data_o  (f_data),
    .cmd_meta_o  (f_meta)
  );

  // command queue between front and back
  assign cmdq_in = {f_op, f_idx, f_data, f_meta};

  fbpa_fifo #(
    .WIDTH (CmdW),
    .DEPTH (fbpa_pkg::CmdqDepth)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cmdq_in),
    .pop_i   (cmd_take),
    .data_o  (cmdq_out),
    .empty_o (cmdq_empty),
    .full_o  (full),
    .count_o (cmdq_count)
  );

  fbpa_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDX_W      (IdxW),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmdq_empty),
    .cmd_op_i    (fbpa_pkg::op_e'(cmdq_out[CmdW-1 -: 2])),
    .cmd_idx_i   (cmdq_out[CmdW-3 -: IdxW]),
    .cmd_data_i  (cmdq_out[MetaW +: ADDR_WIDTH]),
    .cmd_meta_i  (fbpa_pkg::meta_t'(cmdq_out[MetaW-1:0])),
    .cmd_take_o  (cmd_take),
    .res_count_i (resq_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue toward the output ports
  fbpa_fifo #(
    .WIDTH (ResW),
    .DEPTH (fbpa_pkg::ResqDepth)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty),
    .full_o  (resq_full),
    .count_o (resq_count)
  );

  assign status_o          = res_out.status;
  assign granted_address_o = res_out.granted;
  assign in_use_o          = res_out.in_use;

  // the command queue level and the result queue flags stay consistent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!resq_full || !res_push) && ((cmdq_count == '0) == cmdq_empty))
    else $error("queue flags inconsistent");

endmodule

FILE: dv/fixed_block_pool_allocator_tb.sv
// testbench for the fixed block pool allocator: directed and random words, predicted replies
module fixed_block_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PoolSlots   = 256;
  localparam int QuietLimit  = 3000;
  localparam int HoldCycles  = 300;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [1:0]                          cfg_index_i;
  logic [fbpa_pkg::AddrBits-1:0]       cfg_data_i;
  logic                                push;
  logic                                full;
  logic [1:0]                          mode_i;
  logic [fbpa_pkg::AddrBits-1:0]       address_i;
  logic                                empty;
  logic                                pop;
  logic [1:0]                          status_o;
  logic [fbpa_pkg::AddrBits-1:0]       granted_address_o;
  logic [fbpa_pkg::CountBits-1:0]      in_use_o;

  fixed_block_pool_allocator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .push              (push),
    .full              (full),
    .mode_i            (mode_i),
    .address_i         (address_i),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .in_use_o          (in_use_o)
  );

  always #4ns clk_i = ~clk_i;

  // register shadows, latched into the pool on rebuild
  logic [31:0] reg_base;
  logic [16:0] reg_size;
  logic [8:0]  reg_max;

  // pool state as the block should hold it
  logic [31:0]     free_ring [PoolSlots];
  int unsigned     ring_head;
  int unsigned     ring_tail;
  int unsigned     blocks_out;
  int unsigned     pool_blocks;
  logic [63:0]     pool_base_q;
  logic [63:0]     pool_stride;
  logic [63:0]     pool_last;

  fbpa_pkg::res_t  pool_replies_q[$];
  logic [31:0]     held_blocks[$];
  int unsigned     mismatches = 0;
  int unsigned     idle_pct = 11;
  int unsigned     hold_request = 0;
  int unsigned     quiet_cycles = 0;

  // block size rounded up to a power of two, never below four bytes
  function automatic logic [63:0] rounded_block_bytes(logic [16:0] req);
    logic [63:0] p;
    p = 64'd4;
    while (p < {47'd0, req}) p = p << 1;
    return p;
  endfunction

  // refill the free ring from the register shadows and clear the count
  function automatic void rebuild_pool();
    pool_base_q = {32'd0, reg_base};
    pool_stride = rounded_block_bytes(reg_size);
    pool_blocks = (reg_max > PoolSlots) ? PoolSlots : reg_max;
    for (int i = 0; i < PoolSlots; i++) free_ring[i] = '0;
    for (int i = 0; i < pool_blocks; i++) begin
      free_ring[i] = 32'(pool_base_q + 64'(i) * pool_stride);
    end
    pool_last  = (pool_blocks != 0) ? pool_base_q + 64'(pool_blocks - 1) * pool_stride : '0;
    ring_head  = 0;
    ring_tail  = pool_blocks % PoolSlots;
    blocks_out = 0;
  endfunction

  // reply that the pool gives to one word, with the pool state advanced
  function automatic fbpa_pkg::res_t predict_reply(logic [1:0] m, logic [31:0] a);
    fbpa_pkg::res_t r;
    logic [63:0]    a64;
    r.status  = fbpa_pkg::STAT_OK;
    r.granted = '0;
    a64 = {32'd0, a};
    case (m)
      fbpa_pkg::MODE_ALLOC: begin
        if (blocks_out >= pool_blocks) begin
          r.status = fbpa_pkg::STAT_EXHAUSTED;
        end else begin
          r.granted = free_ring[ring_head];
          ring_head = (ring_head + 1) % PoolSlots;
          blocks_out++;
        end
      end
      fbpa_pkg::MODE_FREE: begin
        if (pool_blocks == 0 || a64 < pool_base_q || a64 > pool_last) begin
          r.status = fbpa_pkg::STAT_FOREIGN;
        end else if (blocks_out == 0) begin
          r.status = fbpa_pkg::STAT_OVERFLOW;
        end else begin
          free_ring[ring_tail] = a;
          ring_tail = (ring_tail + 1) % PoolSlots;
          blocks_out--;
        end
      end
      fbpa_pkg::MODE_REBUILD: rebuild_pool();
      default: ;
    endcase
    r.in_use = blocks_out[fbpa_pkg::CountBits-1:0];
    return r;
  endfunction

  // offer one word, wait for it to be taken, then record its reply
  task automatic issue_request(fbpa_pkg::mode_e m, logic [31:0] a);
    fbpa_pkg::res_t r;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    mode_i    <= m;
    address_i <= a;
    do @(posedge clk_i); while (full);
    r = predict_reply(m, a);
    pool_replies_q = {pool_replies_q, r};
    if (m == fbpa_pkg::MODE_ALLOC && r.status == fbpa_pkg::STAT_OK) begin
      held_blocks = {held_blocks, r.granted};
    end
    if (m == fbpa_pkg::MODE_REBUILD) held_blocks.delete();
  endtask

  // stop offering and wait until every reply has been taken
  task automatic drain_pool();
    push <= 1'b0;
    while (pool_replies_q.size() != 0) @(posedge clk_i);
  endtask

  // write all three registers back to back, pool must be idle
  task automatic configure_pool(logic [31:0] base, logic [16:0] size, logic [8:0] cnt);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    idx[0] = fbpa_pkg::CfgBase;     val[0] = base;
    idx[1] = fbpa_pkg::CfgSize;     val[1] = {15'd0, size};
    idx[2] = fbpa_pkg::CfgMaxCount; val[2] = {23'd0, cnt};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    reg_base = base;
    reg_size = size;
    reg_max  = cnt;
  endtask

  // mostly allocate and free of held blocks, the rest odd addresses and modes
  task automatic send_random_items(int unsigned n, int unsigned alloc_bias, bit allow_rebuild);
    int unsigned pick;
    int unsigned idx;
    logic [31:0] a;
    logic [63:0] span;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < alloc_bias) begin
        issue_request(fbpa_pkg::MODE_ALLOC, $urandom());
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          if (held_blocks.size() != 0) begin
            idx = $urandom_range(held_blocks.size() - 1);
            a = held_blocks[idx];
            held_blocks.delete(idx);
            issue_request(fbpa_pkg::MODE_FREE, a);
          end else begin
            issue_request(fbpa_pkg::MODE_ALLOC, $urandom());
          end
        end else if (pick < 80) begin
          // anywhere in range, aligned or not
          if (pool_blocks == 0) begin
            a = $urandom();
          end else begin
            span = pool_last - pool_base_q;
            a = 32'(pool_base_q + ({$urandom(), $urandom()} % (span + 64'd1)));
          end
          issue_request(fbpa_pkg::MODE_FREE, a);
        end else if (pick < 86) begin
          case ($urandom_range(2))
            0:       a = 32'(pool_base_q - 64'd1);
            1:       a = 32'(pool_last);
            default: a = 32'(pool_last + 64'd1);
          endcase
          issue_request(fbpa_pkg::MODE_FREE, a);
        end else if (pick < 92) begin
          issue_request(fbpa_pkg::MODE_FREE, $urandom());
        end else if (pick < 97 || !allow_rebuild) begin
          issue_request(fbpa_pkg::MODE_NONE, $urandom());
        end else begin
          issue_request(fbpa_pkg::MODE_REBUILD, $urandom());
        end
      end
    end
  endtask

  // reset pool: grants, double free, overflow, foreign, unused mode
  task automatic test_default_pool();
    issue_request(fbpa_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
    issue_request(fbpa_pkg::MODE_ALLOC, 32'h0000_0000);
    issue_request(fbpa_pkg::MODE_FREE, 32'h0000_0000);
    issue_request(fbpa_pkg::MODE_FREE, 32'h0000_0000);
    issue_request(fbpa_pkg::MODE_FREE, 32'h0000_0004);
    issue_request(fbpa_pkg::MODE_FREE, 32'd1020);
    issue_request(fbpa_pkg::MODE_FREE, 32'd1021);
    issue_request(fbpa_pkg::MODE_FREE, 32'hFFFF_FFFF);
    issue_request(fbpa_pkg::MODE_NONE, 32'hAAAA_AAAA);
    issue_request(fbpa_pkg::MODE_ALLOC, 32'h5555_5555);
    issue_request(fbpa_pkg::MODE_FREE, 32'h0000_0003);
    issue_request(fbpa_pkg::MODE_REBUILD, 32'h0000_0000);
    drain_pool();
  endtask

  // registers only count after a rebuild; wrapped block is foreign on free
  task automatic test_latch_and_wrap();
    configure_pool(32'hFFFF_FF00, 17'd65536, 9'd300);
    issue_request(fbpa_pkg::MODE_ALLOC, 32'h0);
    issue_request(fbpa_pkg::MODE_REBUILD, 32'h0);
    issue_request(fbpa_pkg::MODE_ALLOC, 32'h0);
    issue_request(fbpa_pkg::MODE_ALLOC, 32'h0);
    issue_request(fbpa_pkg::MODE_FREE, 32'h0000_FF00);
    issue_request(fbpa_pkg::MODE_FREE, 32'hFFFF_FF00);
    drain_pool();
  endtask

  // zero sized pool with zero requested size
  task automatic test_empty_pool();
    configure_pool(32'h0000_1000, 17'd0, 9'd0);
    issue_request(fbpa_pkg::MODE_REBUILD, 32'h0);
    issue_request(fbpa_pkg::MODE_ALLOC, 32'h0);
    issue_request(fbpa_pkg::MODE_FREE, 32'h0000_1000);
    drain_pool();
  endtask

  // one block, odd size rounded up
  task automatic test_single_block();
    configure_pool(32'h0000_2000, 17'd5, 9'd1);
    issue_request(fbpa_pkg::MODE_REBUILD, 32'h0);
    issue_request(fbpa_pkg::MODE_ALLOC, 32'h0);
    issue_request(fbpa_pkg::MODE_ALLOC, 32'h0);
    issue_request(fbpa_pkg::MODE_FREE, 32'h0000_2003);
    drain_pool();
  endtask

  // reader stops for a long stretch while words keep coming
  task automatic test_backpressure();
    configure_pool($urandom(), 17'd16, 9'd256);
    issue_request(fbpa_pkg::MODE_REBUILD, 32'h0);
    hold_request = HoldCycles;
    send_random_items(40, 60, 1'b0);
    drain_pool();
  endtask

  // several random settings, one stretch without idling
  task automatic test_random_phases();
    logic [31:0] base;
    logic [16:0] size;
    logic [8:0]  cnt;
    for (int p = 0; p < 7; p++) begin
      idle_pct = (p == 3) ? 0 : 11;
      case ($urandom_range(5))
        0:       base = 32'h0;
        1:       base = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFFF);
        default: base = $urandom();
      endcase
      case ($urandom_range(5))
        0:       size = 17'($urandom_range(0, 4));
        1:       size = 17'd65536;
        2:       size = 17'(1 << $urandom_range(0, 16));
        3:       size = 17'($urandom_range(0, 65536));
        default: size = 17'($urandom_range(0, 300));
      endcase
      case ($urandom_range(7))
        0:       cnt = 9'd0;
        1:       cnt = 9'd1;
        2:       cnt = 9'd256;
        3:       cnt = 9'($urandom_range(257, 511));
        default: cnt = 9'($urandom_range(2, 24));
      endcase
      configure_pool(base, size, cnt);
      if ($urandom_range(3) != 0) issue_request(fbpa_pkg::MODE_REBUILD, $urandom());
      send_random_items(180, $urandom_range(25, 80), 1'b1);
      drain_pool();
    end
    idle_pct = 11;
  endtask

  // full size pool pushed into exhaustion
  task automatic test_full_pool_walk();
    configure_pool($urandom(), 17'($urandom_range(1, 64)), 9'd256);
    issue_request(fbpa_pkg::MODE_REBUILD, 32'h0);
    send_random_items(340, 90, 1'b0);
  endtask

  // reply reader with random stalls and the long hold
  initial begin : reply_checker
    fbpa_pkg::res_t want;
    int unsigned    hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pool_replies_q.size() == 0) begin
          $error("reply word with nothing pending: status %0d granted %h in_use %0d",
                 status_o, granted_address_o, in_use_o);
          mismatches++;
        end else begin
          want = pool_replies_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (granted_address_o !== want.granted) begin
            $error("granted_address: expected %h, got %h", want.granted, granted_address_o);
            mismatches++;
          end
          if (in_use_o !== want.in_use) begin
            $error("in_use: expected %0d, got %0d", want.in_use, in_use_o);
            mismatches++;
          end
        end
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= rst_ni && ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, then each test in turn
  initial begin
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    mode_i      <= fbpa_pkg::MODE_ALLOC;
    address_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= fbpa_pkg::CfgBase;
    cfg_data_i  <= '0;
    reg_base = 32'h0;
    reg_size = 17'd4;
    reg_max  = 9'd256;
    rebuild_pool();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_pool();
    test_latch_and_wrap();
    test_empty_pool();
    test_single_block();
    test_backpressure();
    test_random_phases();
    test_full_pool_walk();
    drain_pool();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
